// ----- rtl/bmpsp_pkg.sv -----
`default_nettype none
package bmpsp_pkg;

    localparam int DimW = 20;
    localparam int ByteW = 8;
    localparam int HdrCntW = 6;
    localparam int DepthW = 16;

    localparam logic [DimW-1:0] MaxDimReset = DimW'(100000);

    localparam logic [ByteW-1:0] MagicB = 8'h42;
    localparam logic [ByteW-1:0] MagicM = 8'h4D;
    localparam logic [DepthW-1:0] DepthRgb24 = 16'd24;

    localparam logic [HdrCntW-1:0] HdrMagic0 = 6'd0;
    localparam logic [HdrCntW-1:0] HdrMagic1 = 6'd1;
    localparam logic [HdrCntW-1:0] HdrWidth0 = 6'd18;
    localparam logic [HdrCntW-1:0] HdrWidth1 = 6'd19;
    localparam logic [HdrCntW-1:0] HdrWidth2 = 6'd20;
    localparam logic [HdrCntW-1:0] HdrWidth3 = 6'd21;
    localparam logic [HdrCntW-1:0] HdrHeight0 = 6'd22;
    localparam logic [HdrCntW-1:0] HdrHeight1 = 6'd23;
    localparam logic [HdrCntW-1:0] HdrHeight2 = 6'd24;
    localparam logic [HdrCntW-1:0] HdrHeight3 = 6'd25;
    localparam logic [HdrCntW-1:0] HdrDepth0 = 6'd28;
    localparam logic [HdrCntW-1:0] HdrDepth1 = 6'd29;
    localparam logic [HdrCntW-1:0] HdrLast = 6'd53;

    typedef enum logic [1:0] {
        ST_PIXEL     = 2'd0,
        ST_ACCEPT    = 2'd1,
        ST_BAD       = 2'd2,
        ST_PREMATURE = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_PIXELS  = 5'b00010,
        PH_PADDING = 5'b00100,
        PH_DONE    = 5'b01000,
        PH_ERROR   = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        COMP_BLUE  = 2'd0,
        COMP_GREEN = 2'd1,
        COMP_RED   = 2'd2
    } comp_t;

    typedef struct packed {
        status_t          status;
        logic [ByteW-1:0] red;
        logic [ByteW-1:0] green;
        logic [ByteW-1:0] blue;
        logic [DimW-1:0]  row;
        logic [DimW-1:0]  column;
        logic [DimW-1:0]  image_width;
        logic [DimW-1:0]  image_height;
        logic             last_pixel;
    } result_t;

endpackage
`default_nettype wire

// ----- rtl/bmpsp_decode.sv -----
`default_nettype none
module bmpsp_decode (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [bmpsp_pkg::DimW-1:0] cfg_wr_data,
    input  wire logic                     step_en,
    input  wire logic [bmpsp_pkg::ByteW-1:0] data_byte,
    input  wire logic                     end_of_file,
    output logic                          res_valid,
    output bmpsp_pkg::result_t            res
);
    import bmpsp_pkg::*;

    logic [DimW-1:0]    max_dim_reg;
    phase_t             phase_reg, phase_next;
    logic [HdrCntW-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [DimW-1:0]    width_reg, width_next;
    logic               width_hi_reg, width_hi_next;
    logic [DimW-1:0]    height_reg, height_next;
    logic               height_hi_reg, height_hi_next;
    logic [DepthW-1:0]  depth_reg, depth_next;
    comp_t              comp_reg, comp_next;
    logic [ByteW-1:0]   blue_reg, blue_next;
    logic [ByteW-1:0]   green_reg, green_next;
    logic [DimW-1:0]    col_reg, col_next;
    logic [DimW-1:0]    row_reg, row_next;
    logic [1:0]         pad_reg, pad_next;

    logic               bad;
    logic               width_ok, height_ok;
    logic [DimW-1:0]    col_inc, row_inc;
    logic [DimW:0]      row_inc_w, col_inc_w;

    assign col_inc   = col_reg + 1'b1;
    assign row_inc   = row_reg + 1'b1;
    assign col_inc_w = {1'b0, col_reg} + 1'b1;
    assign row_inc_w = {1'b0, row_reg} + 1'b1;

    always_comb begin
        phase_next     = phase_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        width_next     = width_reg;
        width_hi_next  = width_hi_reg;
        height_next    = height_reg;
        height_hi_next = height_hi_reg;
        depth_next     = depth_reg;
        comp_next      = comp_reg;
        blue_next      = blue_reg;
        green_next     = green_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        pad_next       = pad_reg;
        res_valid      = 1'b0;
        res            = '0;
        bad            = 1'b0;
        width_ok       = 1'b0;
        height_ok      = 1'b0;

        case (phase_reg)
            PH_HEADER: begin
                case (hdr_cnt_reg)
                    HdrMagic0:  bad = (data_byte != MagicB);
                    HdrMagic1:  bad = (data_byte != MagicM);
                    HdrWidth0:  width_next[7:0] = data_byte;
                    HdrWidth1:  width_next[15:8] = data_byte;
                    HdrWidth2: begin
                        width_next[19:16] = data_byte[3:0];
                        width_hi_next = width_hi_reg | (data_byte[7:4] != 4'd0);
                    end
                    HdrWidth3:  width_hi_next = width_hi_reg | (data_byte != '0);
                    HdrHeight0: height_next[7:0] = data_byte;
                    HdrHeight1: height_next[15:8] = data_byte;
                    HdrHeight2: begin
                        height_next[19:16] = data_byte[3:0];
                        height_hi_next = height_hi_reg | (data_byte[7:4] != 4'd0);
                    end
                    HdrHeight3: height_hi_next = height_hi_reg | (data_byte != '0);
                    HdrDepth0:  depth_next[7:0] = data_byte;
                    HdrDepth1:  depth_next[15:8] = data_byte;
                    default: ;
                endcase
                width_ok  = !width_hi_next && (width_next != '0) &&
                            (width_next <= max_dim_reg);
                height_ok = !height_hi_next && (height_next != '0) &&
                            (height_next <= max_dim_reg);
                if (!bad && hdr_cnt_reg == HdrLast) begin
                    if (width_ok && height_ok && depth_next == DepthRgb24) begin
                        res_valid        = 1'b1;
                        res.status       = ST_ACCEPT;
                        res.image_width  = width_next;
                        res.image_height = height_next;
                        phase_next       = PH_PIXELS;
                        comp_next        = COMP_BLUE;
                        col_next         = '0;
                        row_next         = '0;
                    end else begin
                        bad = 1'b1;
                    end
                end else if (!bad) begin
                    hdr_cnt_next = hdr_cnt_reg + 1'b1;
                end
                if (bad) begin
                    res_valid  = 1'b1;
                    res        = '0;
                    res.status = ST_BAD;
                    phase_next = PH_ERROR;
                end
            end
            PH_PIXELS: begin
                case (comp_reg)
                    COMP_BLUE: begin
                        blue_next = data_byte;
                        comp_next = COMP_GREEN;
                    end
                    COMP_GREEN: begin
                        green_next = data_byte;
                        comp_next  = COMP_RED;
                    end
                    default: begin
                        res_valid      = 1'b1;
                        res.status     = ST_PIXEL;
                        res.red        = data_byte;
                        res.green      = green_reg;
                        res.blue       = blue_reg;
                        res.row        = row_reg;
                        res.column     = col_reg;
                        res.last_pixel = (row_inc_w == {1'b0, height_reg}) &&
                                         (col_inc_w == {1'b0, width_reg});
                        comp_next      = COMP_BLUE;
                        col_next       = col_inc;
                        if (col_inc == width_reg) begin
                            col_next = '0;
                            pad_next = width_reg[1:0];
                            if (width_reg[1:0] != 2'd0) begin
                                phase_next = PH_PADDING;
                            end else begin
                                row_next   = row_inc;
                                phase_next = (row_inc == height_reg) ? PH_DONE : PH_PIXELS;
                            end
                        end
                    end
                endcase
            end
            PH_PADDING: begin
                pad_next = pad_reg - 1'b1;
                if (pad_reg == 2'd1) begin
                    row_next   = row_inc;
                    phase_next = (row_inc == height_reg) ? PH_DONE : PH_PIXELS;
                end
            end
            default: ;
        endcase

        if (end_of_file) begin
            if (phase_next == PH_HEADER) begin
                res_valid  = 1'b1;
                res        = '0;
                res.status = ST_BAD;
            end else if (phase_next == PH_PIXELS || phase_next == PH_PADDING) begin
                res_valid  = 1'b1;
                res        = '0;
                res.status = ST_PREMATURE;
            end
            phase_next     = PH_HEADER;
            hdr_cnt_next   = '0;
            width_next     = '0;
            width_hi_next  = 1'b0;
            height_next    = '0;
            height_hi_next = 1'b0;
            depth_next     = '0;
            comp_next      = COMP_BLUE;
            blue_next      = '0;
            green_next     = '0;
            col_next       = '0;
            row_next       = '0;
            pad_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_dim_reg   <= MaxDimReset;
            phase_reg     <= PH_HEADER;
            hdr_cnt_reg   <= '0;
            width_reg     <= '0;
            width_hi_reg  <= 1'b0;
            height_reg    <= '0;
            height_hi_reg <= 1'b0;
            depth_reg     <= '0;
            comp_reg      <= COMP_BLUE;
            blue_reg      <= '0;
            green_reg     <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            pad_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                max_dim_reg <= cfg_wr_data;
            end
            if (step_en) begin
                phase_reg     <= phase_next;
                hdr_cnt_reg   <= hdr_cnt_next;
                width_reg     <= width_next;
                width_hi_reg  <= width_hi_next;
                height_reg    <= height_next;
                height_hi_reg <= height_hi_next;
                depth_reg     <= depth_next;
                comp_reg      <= comp_next;
                blue_reg      <= blue_next;
                green_reg     <= green_next;
                col_reg       <= col_next;
                row_reg       <= row_next;
                pad_reg       <= pad_next;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/bmpsp_out_reg.sv -----
`default_nettype none
module bmpsp_out_reg (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire bmpsp_pkg::result_t load_data,
    input  wire logic               m_tready,
    output logic                    free,
    output logic                    m_tvalid,
    output bmpsp_pkg::result_t      m_res
);
    import bmpsp_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_res    = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (free && load) begin
            data_reg <= load_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/bmpsp24_stream_parser_unit.sv -----
// Streaming parser for uncompressed 24-bit BMP files, one file byte per word
// on the slave side (s_tlast marks a file's last byte). Results leave on the
// master side: status in m_tuser (pixel, header accepted, bad format,
// premature end), pixel RGB with row and column, or the accepted size, and
// m_tlast on the image's final pixel. A byte passes an input register, then
// the parse logic into the result register; the block takes one byte every
// cycle while m_tready is high. The user must write max_dimension
// (cfg_wr_data) only while the block is idle; the block does not enforce it.
`default_nettype none
module bmp24_stream_parser_unit (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [19:0]   cfg_wr_data,   // max_dimension
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,       // data_byte
    input  wire logic          s_tlast,       // end_of_file
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [103:0]       m_tdata,       // red, green, blue, row, column,
                                              // image_width, image_height
    output logic [1:0]         m_tuser,       // status
    output logic               m_tlast        // last_pixel
);
    import bmpsp_pkg::*;

    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;
    logic             in_eof_reg;
    logic             out_free;
    logic             step_en;
    logic             res_valid;
    result_t          res;
    result_t          m_res;

    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_eof_reg  <= s_tlast;
        end
    end

    bmpsp_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (step_en),
        .data_byte   (in_byte_reg),
        .end_of_file (in_eof_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    bmpsp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step_en && res_valid),
        .load_data (res),
        .m_tready  (m_tready),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_res     (m_res)
    );

    assign m_tdata = {m_res.image_height, m_res.image_width, m_res.column, m_res.row,
                      m_res.blue, m_res.green, m_res.red};
    assign m_tuser = m_res.status;
    assign m_tlast = m_res.last_pixel;

endmodule
`default_nettype wire
